### sv/assert_macros.svh
// Assertion macros used by the wall boundary RTL.
// No dependencies; included by modules that carry checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define WBVP_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("wbvp check failed");
`define WBVP_ASSERT_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("wbvp forbidden condition");
`else
`define WBVP_ASSERT(lbl, clk, rst_n, prop)
`define WBVP_ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

### sv/wbvp_pkg.sv
// Shared types, widths, codes and rounding helper for the wall boundary block.
// No dependencies.
`timescale 1ns / 1ps
package wbvp_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int LANES      = 3;
	localparam int CO_W       = 32;
	localparam int NRM_W      = 18;
	localparam int FRIC_W     = 18;
	localparam int GS_W       = 31;
	localparam int PP_W       = NRM_W + CO_W;
	localparam int DIST_W     = 53;
	localparam int VN_W       = 37;
	localparam int PR_W       = VN_W + NRM_W;
	localparam int GF_W       = VN_W + FRIC_W + 1;
	localparam int VT_W       = 40;
	localparam int W_W        = 39;
	localparam int POS_W      = 6;
	localparam int NW_W       = 30;
	localparam int NORM_MSB   = 29;
	localparam int SQR_W      = 2 * NW_W;
	localparam int SQ_W       = 64;
	localparam int R_W        = 32;
	localparam int Q_W        = 17;
	localparam int NUM_W      = 48;
	localparam int G_W        = 40;
	localparam int U_W        = Q_W + 1;
	localparam int PROD_W     = G_W + U_W;
	localparam int TERM_W     = 42;
	localparam int RES_W      = 43;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [1:0] {
		CLS_FAR  = 2'd0,
		CLS_OUT  = 2'd1,
		CLS_NEAR = 2'd2
	} node_class_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_NORMAL_X     = 3'd0,
		REG_NORMAL_Y     = 3'd1,
		REG_NORMAL_Z     = 3'd2,
		REG_PLANE_OFFSET = 3'd3,
		REG_FRICTION     = 3'd4,
		REG_GRID_SPACING = 3'd5
	} cfg_reg_t;

	typedef logic signed [CO_W-1:0]  coord_t;
	typedef logic signed [NRM_W-1:0] nrm_t;
	typedef logic signed [VT_W-1:0]  vt_t;
	typedef logic [NW_W-1:0]         nw_t;

	typedef struct packed {
		nrm_t [LANES-1:0]  normal;
		coord_t            offset;
		logic [FRIC_W-1:0] friction;
		logic [GS_W-1:0]   spacing;
	} cfg_t;

	typedef struct packed {
		node_class_t         cls;
		coord_t [LANES-1:0]  v;
		vt_t [LANES-1:0]     vt;
		logic signed [G_W-1:0] g;
	} div_side_t;

	typedef struct packed {
		div_side_t        base;
		nw_t [LANES-1:0]  w;
	} sq_side_t;

	localparam int DIV_SIDE_W = $bits(div_side_t);
	localparam int SQ_SIDE_W  = $bits(sq_side_t);

	// x / 2^FRAC_BITS, rounded to nearest, ties away from zero
	function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] x);
		logic [63:0] m;
		logic [63:0] r;
		m = x[63] ? (64'd0 - x) : x;
		r = (m + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return x[63] ? $signed(64'd0 - r) : $signed(r);
	endfunction
endpackage

### sv/wbvp_front.sv
// Front pipeline: distance, class, normal speed, tangent, normalization, squares.
// Depends on wbvp_pkg.
`timescale 1ns / 1ps
module wbvp_front import wbvp_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  coord_t [LANES-1:0]  pos,
	input  coord_t [LANES-1:0]  vel,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SQ_W-1:0]     out_s,
	output sq_side_t            out_side
);
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;

	assign en_s8 = !vld_s8 || out_ready;
	assign en_s7 = !vld_s7 || en_s8;
	assign en_s6 = !vld_s6 || en_s7;
	assign en_s5 = !vld_s5 || en_s6;
	assign en_s4 = !vld_s4 || en_s5;
	assign en_s3 = !vld_s3 || en_s4;
	assign en_s2 = !vld_s2 || en_s3;
	assign en_s1 = !vld_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= vld_s4;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
		end
	end

	// stage 1: n.p and v.n products
	logic signed [PP_W-1:0] pp_s1 [LANES];
	logic signed [PP_W-1:0] pv_s1 [LANES];
	coord_t [LANES-1:0]     v_s1;
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < LANES; i++) begin
				pp_s1[i] <= $signed(cfg.normal[i]) * $signed(pos[i]);
				pv_s1[i] <= $signed(cfg.normal[i]) * $signed(vel[i]);
			end
			v_s1 <= vel;
		end
	end

	// stage 2: signed distance, band test, vn
	logic signed [DIST_W-1:0] sdist, band, psum;
	node_class_t              cls_c;
	logic signed [VN_W-1:0]   vn_c;
	node_class_t              cls_s2;
	logic signed [VN_W-1:0]   vn_s2;
	coord_t [LANES-1:0]       v_s2;
	always_comb begin
		sdist = DIST_W'(pp_s1[0]) + DIST_W'(pp_s1[1]) + DIST_W'(pp_s1[2])
			- (DIST_W'($signed(cfg.offset)) <<< FRAC_BITS);
		band = -$signed(DIST_W'({cfg.spacing, {(FRAC_BITS + 1){1'b0}}}));
		psum = DIST_W'(pv_s1[0]) + DIST_W'(pv_s1[1]) + DIST_W'(pv_s1[2]);
		vn_c = VN_W'(rnd_frac(64'(psum)));
		if (!sdist[DIST_W-1] && sdist != '0) begin
			cls_c = CLS_OUT;
		end else if (sdist >= band) begin
			cls_c = CLS_NEAR;
		end else begin
			cls_c = CLS_FAR;
		end
	end
	always_ff @(posedge clk) begin
		if (en_s2) begin
			cls_s2 <= cls_c;
			vn_s2  <= vn_c;
			v_s2   <= v_s1;
		end
	end

	// stage 3: vn*n and friction*vn
	logic signed [PR_W-1:0] pr_s3 [LANES];
	logic signed [GF_W-1:0] gf_s3;
	node_class_t            cls_s3;
	coord_t [LANES-1:0]     v_s3;
	always_ff @(posedge clk) begin
		if (en_s3) begin
			for (int i = 0; i < LANES; i++) begin
				pr_s3[i] <= vn_s2 * $signed(cfg.normal[i]);
			end
			gf_s3  <= $signed({1'b0, cfg.friction}) * vn_s2;
			cls_s3 <= cls_s2;
			v_s3   <= v_s2;
		end
	end

	// stage 4: tangent, its magnitudes, g
	div_side_t             base_c, base_s4;
	logic [W_W-1:0]        w_c [LANES];
	logic [W_W-1:0]        w_s4 [LANES];
	always_comb begin
		base_c.cls = cls_s3;
		base_c.v   = v_s3;
		base_c.g   = G_W'(rnd_frac(64'(gf_s3)));
		for (int i = 0; i < LANES; i++) begin
			base_c.vt[i] = VT_W'($signed(v_s3[i])) - VT_W'(rnd_frac(64'(pr_s3[i])));
			w_c[i] = base_c.vt[i][VT_W-1] ? W_W'(-base_c.vt[i]) : W_W'(base_c.vt[i]);
		end
	end
	always_ff @(posedge clk) begin
		if (en_s4) begin
			base_s4 <= base_c;
			w_s4    <= w_c;
		end
	end

	// stage 5: leading one of the largest magnitude (same as of the OR)
	logic [W_W-1:0]   orw;
	logic [POS_W-1:0] msb_c, msb_s5;
	div_side_t        base_s5;
	logic [W_W-1:0]   w_s5 [LANES];
	always_comb begin
		orw   = w_s4[0] | w_s4[1] | w_s4[2];
		msb_c = '0;
		for (int b = 0; b < W_W; b++) begin
			if (orw[b]) msb_c = POS_W'(b);
		end
	end
	always_ff @(posedge clk) begin
		if (en_s5) begin
			msb_s5  <= msb_c;
			base_s5 <= base_s4;
			w_s5    <= w_s4;
		end
	end

	// stage 6: common shift so the largest sits at bit NORM_MSB
	nw_t [LANES-1:0] nw_c, nw_s6;
	div_side_t       base_s6;
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			if (msb_s5 > POS_W'(NORM_MSB)) begin
				nw_c[i] = NW_W'(w_s5[i] >> (msb_s5 - POS_W'(NORM_MSB)));
			end else begin
				nw_c[i] = NW_W'(w_s5[i] << (POS_W'(NORM_MSB) - msb_s5));
			end
		end
	end
	always_ff @(posedge clk) begin
		if (en_s6) begin
			nw_s6   <= nw_c;
			base_s6 <= base_s5;
		end
	end

	// stage 7: squares
	logic [SQR_W-1:0] sq_s7 [LANES];
	sq_side_t         side_s7;
	always_ff @(posedge clk) begin
		if (en_s7) begin
			for (int i = 0; i < LANES; i++) begin
				sq_s7[i] <= nw_s6[i] * nw_s6[i];
			end
			side_s7.base <= base_s6;
			side_s7.w    <= nw_s6;
		end
	end

	// stage 8: sum of squares
	logic [SQ_W-1:0] s_s8;
	sq_side_t        side_s8;
	always_ff @(posedge clk) begin
		if (en_s8) begin
			s_s8    <= SQ_W'(sq_s7[0]) + SQ_W'(sq_s7[1]) + SQ_W'(sq_s7[2]);
			side_s8 <= side_s7;
		end
	end

	assign out_valid = vld_s8;
	assign out_s     = s_s8;
	assign out_side  = side_s8;
endmodule

### sv/wbvp_sqrt.sv
// Pipelined integer square root, one result bit per stage, with sideband.
// Depends on wbvp_pkg.
`timescale 1ns / 1ps
module wbvp_sqrt import wbvp_pkg::*; #(
	parameter int SIDE_W = SQ_SIDE_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [SQ_W-1:0]   in_s,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [R_W-1:0]    out_r,
	output logic [SIDE_W-1:0] out_side
);
	localparam int STEPS = SQ_W / 2;

	logic              vld  [0:STEPS];
	logic [SQ_W-1:0]   rem  [0:STEPS];
	logic [SQ_W-1:0]   root [0:STEPS];
	logic [SIDE_W-1:0] side [0:STEPS];
	logic [STEPS+1:1]  en;

	assign vld[0]       = in_valid;
	assign rem[0]       = in_s;
	assign root[0]      = '0;
	assign side[0]      = in_side;
	assign en[STEPS+1]  = out_ready;
	assign in_ready     = en[1];

	for (genvar k = 1; k <= STEPS; k++) begin : g_stage
		localparam logic [SQ_W-1:0] BITV = SQ_W'(1) << (2 * (STEPS - k));
		logic [SQ_W-1:0] trial, rem_nx, root_nx;

		assign en[k] = !vld[k] || en[k+1];

		always_comb begin
			trial = root[k-1] + BITV;
			if (rem[k-1] >= trial) begin
				rem_nx  = rem[k-1] - trial;
				root_nx = (root[k-1] >> 1) + BITV;
			end else begin
				rem_nx  = rem[k-1];
				root_nx = root[k-1] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (en[k]) begin
				vld[k] <= vld[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem[k]  <= rem_nx;
				root[k] <= root_nx;
				side[k] <= side[k-1];
			end
		end
	end

	assign out_valid = vld[STEPS];
	assign out_r     = R_W'(root[STEPS]);
	assign out_side  = side[STEPS];
endmodule

### sv/wbvp_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, rounded quotient.
// Depends on wbvp_pkg.
`timescale 1ns / 1ps
module wbvp_div import wbvp_pkg::*; #(
	parameter int SIDE_W = DIV_SIDE_W
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [LANES-1:0][NW_W-1:0]  in_w,
	input  logic [R_W-1:0]              in_r,
	input  logic [SIDE_W-1:0]           in_side,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [LANES-1:0][Q_W-1:0]   out_q,
	output logic [SIDE_W-1:0]           out_side
);
	localparam int STEPS = Q_W;

	logic                        vld  [0:STEPS];
	logic [LANES-1:0][NUM_W-1:0] rem  [0:STEPS];
	logic [LANES-1:0][Q_W-1:0]   quo  [0:STEPS];
	logic [R_W-1:0]              dvs  [0:STEPS];
	logic [SIDE_W-1:0]           side [0:STEPS];
	logic [STEPS+1:1]            en;

	// numerator w*2^16 + r/2 gives round to nearest; zero root only with zero w
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			rem[0][l] = NUM_W'({in_w[l], {FRAC_BITS{1'b0}}}) + NUM_W'(in_r >> 1);
		end
	end
	assign vld[0]      = in_valid;
	assign quo[0]      = '0;
	assign dvs[0]      = (in_r == '0) ? R_W'(1) : in_r;
	assign side[0]     = in_side;
	assign en[STEPS+1] = out_ready;
	assign in_ready    = en[1];

	for (genvar k = 1; k <= STEPS; k++) begin : g_stage
		localparam int QB = STEPS - k;
		logic [LANES-1:0][NUM_W-1:0] rem_nx;
		logic [LANES-1:0][Q_W-1:0]   quo_nx;
		logic [NUM_W-1:0]            trial;

		assign en[k] = !vld[k] || en[k+1];

		always_comb begin
			trial = NUM_W'(dvs[k-1]) << QB;
			for (int l = 0; l < LANES; l++) begin
				if (rem[k-1][l] >= trial) begin
					rem_nx[l] = rem[k-1][l] - trial;
					quo_nx[l] = quo[k-1][l] | (Q_W'(1) << QB);
				end else begin
					rem_nx[l] = rem[k-1][l];
					quo_nx[l] = quo[k-1][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld[k] <= 1'b0;
			end else if (en[k]) begin
				vld[k] <= vld[k-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem[k]  <= rem_nx;
				quo[k]  <= quo_nx;
				dvs[k]  <= dvs[k-1];
				side[k] <= side[k-1];
			end
		end
	end

	assign out_valid = vld[STEPS];
	assign out_q     = quo[STEPS];
	assign out_side  = side[STEPS];
endmodule

### sv/wall_boundary_velocity_project_top.sv
// Pipeline: front, square root, divide and output stages, in that order, from input item to result.
// Throughput: one item per cycle while m_axis_tready is high; every stage has its own valid and stalls only when
// the stage after it is full, so bubbles close up under backpressure.
// Reset: arst_n clears all valid bits and loads the default wall (normal +z,
// offset 0, friction 0, spacing 1.0). Config writes are always taken.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module wall_boundary_velocity_project_top import wbvp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z (32 bits each, lowest first)
	input  logic [6*CO_W-1:0]     s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// new_vel_x, new_vel_y, new_vel_z (32 bits each, lowest first)
	output logic [3*CO_W-1:0]     m_axis_tdata,
	// node_class [1:0], saturated [2]
	output logic [2:0]            m_axis_tuser,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.normal[0] <= '0;
			cfg_q.normal[1] <= '0;
			cfg_q.normal[2] <= NRM_W'(1 << FRAC_BITS);
			cfg_q.offset    <= '0;
			cfg_q.friction  <= '0;
			cfg_q.spacing   <= GS_W'(1 << FRAC_BITS);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_NORMAL_X:     cfg_q.normal[0] <= cfg_data[NRM_W-1:0];
				REG_NORMAL_Y:     cfg_q.normal[1] <= cfg_data[NRM_W-1:0];
				REG_NORMAL_Z:     cfg_q.normal[2] <= cfg_data[NRM_W-1:0];
				REG_PLANE_OFFSET: cfg_q.offset    <= cfg_data;
				REG_FRICTION:     cfg_q.friction  <= cfg_data[FRIC_W-1:0];
				REG_GRID_SPACING: cfg_q.spacing   <= cfg_data[GS_W-1:0];
				default: ;
			endcase
		end
	end

	coord_t [LANES-1:0] pos, vel;
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			pos[i] = s_axis_tdata[i*CO_W +: CO_W];
			vel[i] = s_axis_tdata[(LANES + i)*CO_W +: CO_W];
		end
	end

	logic            fr_valid, fr_ready;
	logic [SQ_W-1:0] fr_s;
	sq_side_t        fr_side;

	wbvp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.pos       (pos),
		.vel       (vel),
		.out_valid (fr_valid),
		.out_ready (fr_ready),
		.out_s     (fr_s),
		.out_side  (fr_side)
	);

	logic                 rt_valid, rt_ready;
	logic [R_W-1:0]       rt_r;
	logic [SQ_SIDE_W-1:0] rt_side_vec;
	sq_side_t             rt_side;

	wbvp_sqrt #(.SIDE_W(SQ_SIDE_W)) u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_s      (fr_s),
		.in_side   (fr_side),
		.out_valid (rt_valid),
		.out_ready (rt_ready),
		.out_r     (rt_r),
		.out_side  (rt_side_vec)
	);
	assign rt_side = sq_side_t'(rt_side_vec);

	logic                      dv_valid, dv_ready;
	logic [LANES-1:0][Q_W-1:0] dv_q;
	logic [DIV_SIDE_W-1:0]     dv_side_vec;
	div_side_t                 dv_side;

	wbvp_div #(.SIDE_W(DIV_SIDE_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rt_valid),
		.in_ready  (rt_ready),
		.in_w      (rt_side.w),
		.in_r      (rt_r),
		.in_side   (rt_side.base),
		.out_valid (dv_valid),
		.out_ready (dv_ready),
		.out_q     (dv_q),
		.out_side  (dv_side_vec)
	);
	assign dv_side = div_side_t'(dv_side_vec);

	// stage 1: signed unit tangent times g
	logic vld_s1, vld_s2, en_s1, en_s2;
	assign en_s2    = !vld_s2 || m_axis_tready;
	assign en_s1    = !vld_s1 || en_s2;
	assign dv_ready = en_s1;

	logic signed [U_W-1:0]    u_c [LANES];
	logic signed [PROD_W-1:0] prod_s1 [LANES];
	div_side_t                base_s1;
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			u_c[i] = dv_side.vt[i][VT_W-1] ? -$signed({1'b0, dv_q[i]})
				: $signed({1'b0, dv_q[i]});
		end
	end
	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int i = 0; i < LANES; i++) begin
				prod_s1[i] <= dv_side.g * u_c[i];
			end
			base_s1 <= dv_side;
		end
	end

	// stage 2: add friction term, saturate, pick by class
	logic signed [TERM_W-1:0] term;
	logic signed [RES_W-1:0]  res;
	logic [CO_W-1:0]          vel_c [LANES];
	logic                     sat_c;
	logic [CO_W-1:0]          vel_s2 [LANES];
	node_class_t              cls_s2;
	logic                     sat_s2;
	always_comb begin
		sat_c = 1'b0;
		term  = '0;
		res   = '0;
		for (int i = 0; i < LANES; i++) begin
			term = TERM_W'(rnd_frac(64'(prod_s1[i])));
			res  = RES_W'($signed(base_s1.vt[i])) + RES_W'(term);
			case (base_s1.cls)
				CLS_OUT: vel_c[i] = '0;
				CLS_NEAR: begin
					if (!res[RES_W-1] && res[RES_W-2:CO_W-1] != '0) begin
						vel_c[i] = {1'b0, {(CO_W-1){1'b1}}};
						sat_c    = 1'b1;
					end else if (res[RES_W-1] && res[RES_W-2:CO_W-1] != '1) begin
						vel_c[i] = {1'b1, {(CO_W-1){1'b0}}};
						sat_c    = 1'b1;
					end else begin
						vel_c[i] = res[CO_W-1:0];
					end
				end
				default: vel_c[i] = base_s1.v[i];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= dv_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) begin
			vel_s2 <= vel_c;
			cls_s2 <= base_s1.cls;
			sat_s2 <= sat_c;
		end
	end

	assign m_axis_tvalid = vld_s2;
	always_comb begin
		for (int i = 0; i < LANES; i++) begin
			m_axis_tdata[i*CO_W +: CO_W] = vel_s2[i];
		end
	end
	assign m_axis_tuser = {sat_s2, cls_s2};

	`WBVP_ASSERT(a_out_zeroed, clk, arst_n, (vld_s2 && cls_s2 == CLS_OUT) |-> (m_axis_tdata == '0 && !sat_s2))
	`WBVP_ASSERT_NEVER(a_sat_only_near, clk, arst_n, vld_s2 && sat_s2 && cls_s2 != CLS_NEAR)
	`WBVP_ASSERT(a_s1_holds, clk, arst_n, (vld_s1 && !en_s1) |=> (vld_s1 && $stable(base_s1)))
endmodule

### tb/sv/tb_wall_boundary_velocity_project_top.sv
// Self-checking bench for the wall boundary velocity block: random and directed nodes,
// several wall settings, a bit-exact software predictor and an in-order result check.
// Depends on wbvp_pkg and wall_boundary_velocity_project_top.
`timescale 1ns / 1ps

class wall_scoreboard;
	logic [3*32+2:0] pending[$];
	int errors;
	int reports;

	function new();
		errors = 0;
		reports = 0;
	endfunction

	function void note_node(logic [3*32+2:0] expected);
		pending.push_back(expected);
	endfunction

	function void check_result(logic [95:0] data, logic [2:0] user);
		logic [98:0] want;
		if (pending.size() == 0) begin
			errors++;
			if (reports < 10) begin
				reports++;
				$display("unexpected result %h user %h", data, user);
			end
			return;
		end
		want = pending.pop_front();
		for (int f = 0; f < 5; f++) begin
			logic [31:0] e;
			logic [31:0] a;
			e = (f < 3) ? want[f*32 +: 32] : (f == 3 ? 32'(want[97:96]) : 32'(want[98]));
			a = (f < 3) ? data[f*32 +: 32] : (f == 3 ? 32'(user[1:0]) : 32'(user[2]));
			if (e !== a) begin
				errors++;
				if (reports < 10) begin
					reports++;
					$display("field %0d mismatch: expected %h got %h", f, e, a);
				end
			end
		end
	endfunction
endclass

module tb_wall_boundary_velocity_project_top;
	import wbvp_pkg::*;

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [6*CO_W-1:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [3*CO_W-1:0] m_axis_tdata;
	logic [2:0] m_axis_tuser;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	wall_boundary_velocity_project_top uut (.*);

	wall_scoreboard board;
	longint wall_n[3];
	longint wall_offset;
	longint wall_friction;
	longint wall_spacing;
	int idle_cycles;
	bit timed_out;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	function automatic longint mag64(longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic longint round_frac(longint x);
		longint m;
		m = (mag64(x) + 64'sd32768) >>> 16;
		return x < 0 ? -m : m;
	endfunction

	function automatic longint int_sqrt(longint s);
		longint r;
		longint b;
		r = 0;
		b = 64'sd1 << 62;
		while (b > s) b = b >>> 2;
		while (b != 0) begin
			if (s >= r + b) begin
				s = s - (r + b);
				r = (r >>> 1) + b;
			end else begin
				r = r >>> 1;
			end
			b = b >>> 2;
		end
		return r;
	endfunction

	function automatic logic [98:0] wall_velocity(logic [6*32-1:0] node);
		longint p[3];
		longint v[3];
		longint res[3];
		longint vt[3];
		longint u[3];
		longint w[3];
		longint sdist;
		longint band;
		longint vn;
		longint mx;
		longint s;
		longint r;
		longint g;
		longint x;
		logic [1:0] cls;
		bit sat;
		int lsh;
		int rsh;
		logic [98:0] out;
		sdist = 0;
		sat = 0;
		for (int i = 0; i < 3; i++) begin
			p[i] = longint'($signed(node[i*32 +: 32]));
			v[i] = longint'($signed(node[(3+i)*32 +: 32]));
			sdist += wall_n[i] * p[i];
			u[i] = 0;
		end
		sdist -= wall_offset * 65536;
		band = -(wall_spacing * 2 * 65536);
		if (sdist > 0) begin
			cls = CLS_OUT;
			for (int i = 0; i < 3; i++) res[i] = 0;
		end else if (sdist >= band) begin
			cls = CLS_NEAR;
			vn = 0;
			for (int i = 0; i < 3; i++) vn += v[i] * wall_n[i];
			vn = round_frac(vn);
			mx = 0;
			for (int i = 0; i < 3; i++) begin
				vt[i] = v[i] - round_frac(vn * wall_n[i]);
				w[i] = mag64(vt[i]);
				if (w[i] > mx) mx = w[i];
			end
			if (mx != 0) begin
				lsh = 0;
				rsh = 0;
				s = 0;
				while ((mx >>> rsh) >= (64'sd1 << 30)) rsh++;
				while ((mx <<< lsh) < (64'sd1 << 29)) lsh++;
				for (int i = 0; i < 3; i++) begin
					w[i] = (w[i] >>> rsh) <<< lsh;
					s += w[i] * w[i];
				end
				r = int_sqrt(s);
				for (int i = 0; i < 3; i++) begin
					x = ((w[i] <<< 16) + (r >>> 1)) / r;
					u[i] = vt[i] < 0 ? -x : x;
				end
			end
			g = round_frac(wall_friction * vn);
			for (int i = 0; i < 3; i++) begin
				x = vt[i] + round_frac(g * u[i]);
				if (x > 64'sd2147483647) begin
					x = 64'sd2147483647;
					sat = 1;
				end else if (x < -64'sd2147483648) begin
					x = -64'sd2147483648;
					sat = 1;
				end
				res[i] = x;
			end
		end else begin
			cls = CLS_FAR;
			for (int i = 0; i < 3; i++) res[i] = v[i];
		end
		for (int i = 0; i < 3; i++) out[i*32 +: 32] = res[i][31:0];
		out[97:96] = cls;
		out[98] = sat;
		return out;
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [31:0] value);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_NORMAL_X: wall_n[0] = longint'($signed(value[17:0]));
			REG_NORMAL_Y: wall_n[1] = longint'($signed(value[17:0]));
			REG_NORMAL_Z: wall_n[2] = longint'($signed(value[17:0]));
			REG_PLANE_OFFSET: wall_offset = longint'($signed(value));
			REG_FRICTION: wall_friction = longint'(value[17:0]);
			REG_GRID_SPACING: wall_spacing = longint'(value[30:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic set_wall(int nx, int ny, int nz, int offset, int fric, int spacing);
		write_reg(REG_NORMAL_X, 32'(nx));
		write_reg(REG_NORMAL_Y, 32'(ny));
		write_reg(REG_NORMAL_Z, 32'(nz));
		write_reg(REG_PLANE_OFFSET, 32'(offset));
		write_reg(REG_FRICTION, 32'(fric));
		write_reg(REG_GRID_SPACING, 32'(spacing));
	endtask

	// called at a falling edge; leaves tvalid high on return
	task automatic send_node(logic [6*32-1:0] node);
		s_axis_tvalid <= 1;
		s_axis_tdata <= node;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		board.note_node(wall_velocity(node));
		@(negedge clk);
	endtask

	task automatic drain();
		while (board.pending.size() != 0 && !timed_out) @(posedge clk);
		repeat (70) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom();
			1: return 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
			2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
			default: return 32'($signed($urandom_range(0, 2 << 16)) - (1 << 16));
		endcase
	endfunction

	// positions mostly near the plane so all three classes show up
	task automatic send_random(int count);
		logic [6*32-1:0] node;
		int burst;
		int done;
		done = 0;
		while (done < count) begin
			burst = $urandom_range(1, 20);
			for (int b = 0; b < burst && done < count; b++) begin
				for (int f = 0; f < 6; f++)
					node[f*32 +: 32] = rand_coord(f < 3 ? $urandom_range(1, 3) :
						$urandom_range(0, 3));
				if ($urandom_range(0, 7) == 0) node = {$urandom(), $urandom(), $urandom(),
					$urandom(), $urandom(), $urandom()};
				send_node(node);
				done++;
			end
			if ($urandom_range(0, 2) != 0) begin
				s_axis_tvalid <= 0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
		s_axis_tvalid <= 0;
	endtask

	// receiver stall pattern
	initial begin
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			case ($urandom_range(0, 3))
				0: m_axis_tready <= 1;
				1: m_axis_tready <= $urandom_range(0, 1);
				2: m_axis_tready <= ($urandom_range(0, 4) != 0);
				default: m_axis_tready <= ($urandom_range(0, 4) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata, m_axis_tuser);
	end

	// watchdog on cycles with no handshake
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			timed_out = 1;
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		logic [6*32-1:0] node;
		board = new();
		timed_out = 0;
		idle_cycles = 0;
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		cfg_valid = 0;
		cfg_index = REG_NORMAL_X;
		cfg_data = '0;
		wall_n[0] = 0;
		wall_n[1] = 0;
		wall_n[2] = 65536;
		wall_offset = 0;
		wall_friction = 0;
		wall_spacing = 65536;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed nodes at reset wall: outside, band edge, far, extremes, zero tangent
		send_node({32'd100, 32'd200, 32'd300, 32'd1, 32'd0, 32'd0});
		send_node({32'd100, 32'd200, 32'd300, -32'sd131072, 32'd0, 32'd0});
		send_node({32'd100, 32'd200, 32'd300, -32'sd131073, 32'd0, 32'd0});
		send_node({32'd5 << 16, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
		send_node({32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff,
			32'h7fffffff});
		send_node({32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffff0000, 32'h0, 32'h0});
		s_axis_tvalid <= 0;
		drain();

		set_wall(0, 0, 65536, 0, 262143, 1);
		send_node({32'h7fffffff, 32'h80000000, 32'h80000000, 32'hffffffff, 32'h0, 32'h0});
		send_node({32'h0, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0, 32'h0});
		send_node({32'h1, 32'h80000000, 32'h7fffffff, 32'h0, 32'h0, 32'h0});
		send_node({32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0});
		s_axis_tvalid <= 0;
		drain();

		// widest band with the most negative offset
		set_wall(-65536, 65536, 65536, 32'h80000000, 65536, 32'h7fffffff);
		send_node({32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h7fffffff, 32'h0});
		send_node({32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h0, 32'h0});
		s_axis_tvalid <= 0;
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: set_wall(0, 0, 65536, 0, 32768, 65536);
				1: set_wall(46341, 0, -46341, 32'h7fffffff, 262143, 32'h7fffffff);
				2: set_wall(-65536, 0, 0, 65536, 0, 1);
				3: set_wall(37837, 37837, 37837, -3 << 16, 98304, 32768);
				4: set_wall($urandom_range(0, 131072) - 65536, $urandom_range(0, 131072) - 65536,
					$urandom_range(0, 131072) - 65536, $urandom_range(0, 1 << 20) - (1 << 19),
					$urandom_range(0, 262143), $urandom_range(1, 1 << 18));
				default: set_wall(0, 65536, 0, 0, 131072, 1 << 17);
			endcase
			send_random(125);
			drain();
		end

		if (board.pending.size() == 0 && board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule

### wall_boundary_velocity_project_top.f
+incdir+sv
sv/wbvp_pkg.sv
sv/wbvp_front.sv
sv/wbvp_sqrt.sv
sv/wbvp_div.sv
sv/wall_boundary_velocity_project_top.sv
tb/sv/tb_wall_boundary_velocity_project_top.sv
